@@ rtl/abm_pkg.sv @@
// Shared types and constants for the audio block level meter.
// No dependencies; every other file in rtl imports this package.
package abm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 15;
  localparam int APERTURE_DEF  = 16;
  localparam int MAX_BLOCK_DEF = 4096;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'h7fff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LVL_START,
    S_LVL_WAIT,
    S_RING,
    S_LOAD
  } abm_state_t;

endpackage

@@ rtl/abm_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on abm_pkg only through the import convention of the project.
module abm_divider #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  import abm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/abm_ring.sv @@
// Ring of recent block levels: one memory with a registered read port and
// per-entry valid bits so that unwritten entries read as zero after reset.
// Depends on abm_pkg.
module abm_ring #(
  parameter int APERTURE = abm_pkg::APERTURE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [$clog2(APERTURE)-1:0]        rd_idx,
  output logic [abm_pkg::LEVEL_W-1:0]        rd_level,
  input  logic                               wr_en,
  input  logic [$clog2(APERTURE)-1:0]        wr_idx,
  input  logic [abm_pkg::LEVEL_W-1:0]        wr_level
);
  import abm_pkg::*;

  logic [LEVEL_W-1:0]  mem [APERTURE];
  logic [APERTURE-1:0] valid_r;
  logic [LEVEL_W-1:0]  rd_data_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_level;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_level = rd_valid_r ? rd_data_r : '0;

endmodule

@@ rtl/audio_block_level_meter.sv @@
// Top level of the audio block level meter: sequencer, accumulator, ring sum
// and output register. Depends on abm_pkg, abm_divider and abm_ring.
//
// Usage: signed 16-bit samples come in on the in_ channel, one per beat, with
// in_last high on the final sample of a block. Each sample adds its absolute
// value (the most negative code counts as full scale) to the accumulator.
// Samples beyond MAX_BLOCK in one block are dropped and set the overflow flag.
// In S_IDLE, beats without in_last stream at one per clock; only a block end
// stalls in_ready. A beat with in_last yields exactly one out_ beat: the block
// level (mean absolute sample), the average of the last APERTURE block
// levels, and the overflow flag. The block mean runs on a serial divider
// that produces one quotient bit per cycle, DIV_W (the accumulator width) bits
// in all; the ring average is a multiply by a rounded-up reciprocal of
// APERTURE. A block end keeps in_ready low through S_LVL_START, S_LVL_WAIT
// (until the divider is done), S_RING and S_LOAD, and the result beat is
// offered from the cycle in which in_ready returns. The result sits in an
// output register, so new samples are accepted while it waits for out_ready;
// if a further block end completes before that, the sequencer holds until the
// pending beat is taken. Reset clears the accumulator, the count, the ring
// (through per-entry valid bits), the ring sum and the output valid.
module audio_block_level_meter #(
  parameter int APERTURE  = abm_pkg::APERTURE_DEF,
  parameter int MAX_BLOCK = abm_pkg::MAX_BLOCK_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [abm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [abm_pkg::LEVEL_W-1:0]          out_block_level,
  output logic [abm_pkg::LEVEL_W-1:0]          out_average_level,
  output logic                                 out_overflow
);
  import abm_pkg::*;

  // Widths follow from the parameters: the accumulator holds MAX_BLOCK full
  // scale samples and the ring sum holds APERTURE full scale levels.
  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int ACC_W  = $clog2(int'(FULL_SCALE) * MAX_BLOCK + 1);
  localparam int SUM_W  = $clog2(int'(FULL_SCALE) * APERTURE + 1);
  localparam int IDX_W  = $clog2(APERTURE);
  localparam int DIV_W  = ACC_W;
  localparam int DVS_W  = CNT_W;

  // Ring average by reciprocal multiplication. With the multiplier rounded
  // up and this shift, the top bits of sum * AVG_MULT equal
  // floor(sum / APERTURE) for every sum that SUM_W bits can hold.
  localparam int AVG_SHIFT = SUM_W + $clog2(APERTURE);
  localparam int PROD_W    = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] AVG_MULT = (SUM_W+1)'(
    ((longint'(1) << AVG_SHIFT) + longint'(APERTURE) - 1) / longint'(APERTURE));

  abm_state_t state_r, state_nxt;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_avg_r;
  logic               out_ovf_r;

  logic               in_beat;
  logic               load_out;
  logic [LEVEL_W-1:0] magnitude;
  logic [SAMPLE_W-1:0] negated;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_busy;
  logic               div_done;
  logic [DIV_W-1:0]   div_quotient;
  logic [LEVEL_W-1:0] quo_clamped;

  logic [PROD_W-1:0]  avg_product;
  logic [LEVEL_W-1:0] avg_level;

  logic               ring_rd_en;
  logic               ring_wr_en;
  logic [LEVEL_W-1:0] ring_old;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  // Absolute value; the most negative code has no positive twin and clamps.
  assign negated   = SAMPLE_W'(~in_sample) + SAMPLE_W'(1);
  assign magnitude = !in_sample[SAMPLE_W-1] ? in_sample[LEVEL_W-1:0] :
                     negated[SAMPLE_W-1] ? FULL_SCALE : negated[LEVEL_W-1:0];

  assign quo_clamped = (|div_quotient[DIV_W-1:LEVEL_W]) ? FULL_SCALE :
                       div_quotient[LEVEL_W-1:0];

  assign avg_product = PROD_W'(sum_r) * PROD_W'(AVG_MULT);
  assign avg_level   = avg_product[AVG_SHIFT +: LEVEL_W];

  abm_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  abm_ring #(
    .APERTURE (APERTURE)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (ring_rd_en),
    .rd_idx   (idx_r),
    .rd_level (ring_old),
    .wr_en    (ring_wr_en),
    .wr_idx   (idx_r),
    .wr_level (level_r)
  );

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    level_nxt    = level_r;
    div_start    = 1'b0;
    div_dividend = DIV_W'(acc_r);
    div_divisor  = DVS_W'(count_r);
    ring_rd_en   = 1'b0;
    ring_wr_en   = 1'b0;
    load_out     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (count_r < CNT_W'(MAX_BLOCK)) begin
            acc_nxt   = acc_r + ACC_W'(magnitude);
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_LVL_START;
          end
        end
      end
      S_LVL_START: begin
        // Block mean, and fetch the ring entry about to be replaced.
        div_start  = 1'b1;
        ring_rd_en = 1'b1;
        state_nxt  = S_LVL_WAIT;
      end
      S_LVL_WAIT: begin
        if (div_done) begin
          level_nxt = quo_clamped;
          state_nxt = S_RING;
        end
      end
      S_RING: begin
        ring_wr_en = 1'b1;
        sum_nxt    = sum_r - SUM_W'(ring_old) + SUM_W'(level_r);
        idx_nxt    = (idx_r == IDX_W'(APERTURE - 1)) ? '0 : idx_r + 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        // Wait here only if the previous result has not been taken yet.
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          acc_nxt   = '0;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    if (load_out) begin
      out_level_r <= level_r;
      out_avg_r   <= avg_level;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_level   = out_level_r;
  assign out_average_level = out_avg_r;
  assign out_overflow      = out_ovf_r;

  // The shared divider is never restarted while it is still working.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The sample count never passes the block limit.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCK))
    else $error("sample count above MAX_BLOCK");

  // Overflow is only raised once the block is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_W'(MAX_BLOCK)))
    else $error("overflow flag set on a block that is not full");

  // The ring sum stays within what APERTURE full-scale levels can add up to.
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(int'(FULL_SCALE) * APERTURE))
    else $error("ring sum out of range");

endmodule
